// ===== design/dtg_pkg.sv =====
// shared types, constants and the sine table for the dds tone generator
// no dependencies
`default_nettype none

package dtg_pkg;

    localparam int AUDIO_RATE  = 16000;
    localparam int RATE_SHIFT  = 7;
    localparam int RATE_ODD    = AUDIO_RATE >> RATE_SHIFT;
    localparam int FRAC_BITS   = 32 - RATE_SHIFT;

    localparam logic [8:0]  ENV_FULL   = 9'd256;
    localparam logic [14:0] AMP_RESET  = 15'd9000;
    localparam logic [8:0]  RAMP_RESET = 9'd4;
    localparam logic [16:0] AMP_FULL   = 17'd32767;

    // step = quo<<25 + whole*rem + (frac*rem) / odd rate, with freq = quo * odd rate + rem
    localparam logic [18:0] STEP_WHOLE = 19'((64'd1 << FRAC_BITS) / RATE_ODD);
    localparam logic [5:0]  STEP_FRAC  = 6'((64'd1 << FRAC_BITS) % RATE_ODD);

    // reciprocal constants for division by the odd rate factor
    localparam int          QUO_SHIFT = 23;
    localparam logic [16:0] RECIP_QUO = 17'(((64'd1 << QUO_SHIFT) + RATE_ODD - 1) / RATE_ODD);
    localparam int          FRC_SHIFT = 20;
    localparam logic [13:0] RECIP_FRC = 14'(((64'd1 << FRC_SHIFT) + RATE_ODD - 1) / RATE_ODD);

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TONE    = 2'd1;
    localparam logic [1:0] MODE_SILENCE = 2'd2;

    localparam logic CFG_AMP  = 1'b0;
    localparam logic CFG_RAMP = 1'b1;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD_TICK,
        OP_LOAD_TONE,
        OP_SILENCE,
        OP_TONE_B,
        OP_TONE_C,
        OP_TONE_D,
        OP_TONE_E,
        OP_TONE_COMMIT,
        OP_AMP,
        OP_GAIN,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    // magnitude of round(32767*sin(2*pi*idx/256)); sign is idx[7]
    function automatic logic [14:0] sine_mag(input logic [7:0] idx);
        logic [6:0]  q;
        logic [6:0]  m;
        logic [14:0] v;
        q = idx[6:0];
        m = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
        case (m)
            7'd0:  v = 15'd0;
            7'd1:  v = 15'd804;
            7'd2:  v = 15'd1608;
            7'd3:  v = 15'd2410;
            7'd4:  v = 15'd3212;
            7'd5:  v = 15'd4011;
            7'd6:  v = 15'd4808;
            7'd7:  v = 15'd5602;
            7'd8:  v = 15'd6393;
            7'd9:  v = 15'd7179;
            7'd10: v = 15'd7962;
            7'd11: v = 15'd8739;
            7'd12: v = 15'd9512;
            7'd13: v = 15'd10278;
            7'd14: v = 15'd11039;
            7'd15: v = 15'd11793;
            7'd16: v = 15'd12539;
            7'd17: v = 15'd13279;
            7'd18: v = 15'd14010;
            7'd19: v = 15'd14732;
            7'd20: v = 15'd15446;
            7'd21: v = 15'd16151;
            7'd22: v = 15'd16846;
            7'd23: v = 15'd17530;
            7'd24: v = 15'd18204;
            7'd25: v = 15'd18868;
            7'd26: v = 15'd19519;
            7'd27: v = 15'd20159;
            7'd28: v = 15'd20787;
            7'd29: v = 15'd21403;
            7'd30: v = 15'd22005;
            7'd31: v = 15'd22594;
            7'd32: v = 15'd23170;
            7'd33: v = 15'd23731;
            7'd34: v = 15'd24279;
            7'd35: v = 15'd24811;
            7'd36: v = 15'd25329;
            7'd37: v = 15'd25832;
            7'd38: v = 15'd26319;
            7'd39: v = 15'd26790;
            7'd40: v = 15'd27245;
            7'd41: v = 15'd27683;
            7'd42: v = 15'd28105;
            7'd43: v = 15'd28510;
            7'd44: v = 15'd28898;
            7'd45: v = 15'd29268;
            7'd46: v = 15'd29621;
            7'd47: v = 15'd29956;
            7'd48: v = 15'd30273;
            7'd49: v = 15'd30571;
            7'd50: v = 15'd30852;
            7'd51: v = 15'd31113;
            7'd52: v = 15'd31356;
            7'd53: v = 15'd31580;
            7'd54: v = 15'd31785;
            7'd55: v = 15'd31971;
            7'd56: v = 15'd32137;
            7'd57: v = 15'd32285;
            7'd58: v = 15'd32412;
            7'd59: v = 15'd32521;
            7'd60: v = 15'd32609;
            7'd61: v = 15'd32678;
            7'd62: v = 15'd32728;
            7'd63: v = 15'd32757;
            7'd64: v = 15'd32767;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/dtg_ctrl.sv =====
// controller state machine for the dds tone generator
// depends on dtg_pkg
`default_nettype none

module dtg_ctrl
    import dtg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [1:0] mode,
    output logic            sample_valid,
    input  wire logic       sample_ready,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AMP,
        ST_GAIN,
        ST_OUT,
        ST_TONE_B,
        ST_TONE_C,
        ST_TONE_D,
        ST_TONE_E,
        ST_TONE_F
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   sample_valid_reg;
    logic   sample_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        sample_valid_next = sample_valid_reg && !sample_ready;
        cmd.op            = OP_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (mode)
                        MODE_TICK:
                        begin
                            cmd.op     = OP_LOAD_TICK;
                            state_next = ST_AMP;
                        end
                        MODE_TONE:
                        begin
                            cmd.op     = OP_LOAD_TONE;
                            state_next = ST_TONE_B;
                        end
                        MODE_SILENCE:
                        begin
                            cmd.op = OP_SILENCE;
                        end
                        default:
                        begin
                            cmd.op = OP_IDLE;
                        end
                    endcase
                end
            end
            ST_AMP:
            begin
                cmd.op     = OP_AMP;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!sample_valid_reg || sample_ready)
                begin
                    cmd.op            = OP_OUT;
                    sample_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_TONE_B:
            begin
                cmd.op     = OP_TONE_B;
                state_next = ST_TONE_C;
            end
            ST_TONE_C:
            begin
                cmd.op     = OP_TONE_C;
                state_next = ST_TONE_D;
            end
            ST_TONE_D:
            begin
                cmd.op     = OP_TONE_D;
                state_next = ST_TONE_E;
            end
            ST_TONE_E:
            begin
                cmd.op     = OP_TONE_E;
                state_next = ST_TONE_F;
            end
            ST_TONE_F:
            begin
                cmd.op     = OP_TONE_COMMIT;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_valid_reg <= sample_valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign sample_valid = sample_valid_reg;

endmodule

`default_nettype wire

// ===== design/dtg_datapath.sv =====
// datapath for the dds tone generator: phase, step, envelope, shared multiplier
// depends on dtg_pkg
`default_nettype none

module dtg_datapath
    import dtg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    input  wire logic [15:0]        freq,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [14:0]        cfg_data,
    output logic signed [15:0]      sample
);

    // architectural state
    logic [31:0] phase_reg, phase_next;
    logic [31:0] tone_step_reg, tone_step_next;
    logic [31:0] held_step_reg, held_step_next;
    logic [8:0]  gain_reg, gain_next;
    logic [8:0]  target_reg, target_next;
    logic [14:0] amp_reg, amp_next;
    logic [8:0]  ramp_reg, ramp_next;

    // working registers
    logic [38:0] prod_reg, prod_next;
    logic [15:0] freq_reg, freq_next;
    logic [9:0]  quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [14:0] mag_reg, mag_next;
    logic        neg_reg, neg_next;
    logic        active_reg, active_next;
    logic signed [15:0] sample_reg, sample_next;

    logic [29:0] mul_a;
    logic [18:0] mul_b;
    logic [48:0] mul_p;

    logic [31:0] eff_step;
    logic [8:0]  gain_calc;
    logic [9:0]  gain_up;
    logic [9:0]  gain_floor;
    logic [15:0] rem_wide;
    logic [5:0]  frac_part;
    logic [31:0] step_new;
    logic [30:0] scaled;
    logic [16:0] quo_rem;
    logic [15:0] mag_out;

    assign mul_p = {19'd0, mul_a} * {30'd0, mul_b};

    assign eff_step   = (tone_step_reg != 32'd0) ? tone_step_reg : held_step_reg;
    assign gain_up    = {1'b0, gain_reg} + {1'b0, ramp_reg};
    assign gain_floor = {1'b0, ramp_reg} + {1'b0, target_reg};

    always_comb
    begin
        if (gain_reg < target_reg)
        begin
            gain_calc = (gain_up > {1'b0, target_reg}) ? target_reg : gain_up[8:0];
        end
        else if (gain_reg > target_reg)
        begin
            gain_calc = ({1'b0, gain_reg} > gain_floor) ? 9'(gain_reg - ramp_reg) : target_reg;
        end
        else
        begin
            gain_calc = gain_reg;
        end
    end

    assign rem_wide  = freq_reg - prod_reg[15:0];
    assign frac_part = prod_reg[25:20];
    assign step_new  = acc_reg + {26'd0, frac_part};

    // divide by 256 * 32767: shift, then estimate and correct once
    assign scaled  = prod_reg[38:8];
    assign quo_rem = {2'b00, scaled[14:0]} + {1'b0, scaled[30:15]};
    assign mag_out = 16'(scaled[30:15]) + ((quo_rem >= AMP_FULL) ? 16'd1 : 16'd0);

    always_comb
    begin
        phase_next     = phase_reg;
        tone_step_next = tone_step_reg;
        held_step_next = held_step_reg;
        gain_next      = gain_reg;
        target_next    = target_reg;
        amp_next       = amp_reg;
        ramp_next      = ramp_reg;
        prod_next      = prod_reg;
        freq_next      = freq_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        active_next    = active_reg;
        sample_next    = sample_reg;
        mul_a          = 30'd0;
        mul_b          = 19'd0;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_AMP:  amp_next  = cfg_data;
                CFG_RAMP: ramp_next = cfg_data[8:0];
                default:  amp_next  = amp_reg;
            endcase
        end

        case (cmd.op)
            OP_LOAD_TICK:
            begin
                gain_next   = gain_calc;
                mag_next    = sine_mag(phase_reg[31:24]);
                neg_next    = phase_reg[31];
                active_next = (gain_calc != 9'd0) && (eff_step != 32'd0);
                if ((gain_calc != 9'd0) && (eff_step != 32'd0))
                begin
                    phase_next = phase_reg + eff_step;
                end
            end
            OP_AMP:
            begin
                mul_a     = {15'd0, mag_reg};
                mul_b     = {4'd0, amp_reg};
                prod_next = mul_p[38:0];
            end
            OP_GAIN:
            begin
                mul_a     = prod_reg[29:0];
                mul_b     = {10'd0, gain_reg};
                prod_next = mul_p[38:0];
            end
            OP_OUT:
            begin
                if (!active_reg)
                begin
                    sample_next = 16'sd0;
                end
                else if (neg_reg)
                begin
                    sample_next = signed'(16'(16'd0 - mag_out));
                end
                else
                begin
                    sample_next = signed'(mag_out);
                end
            end
            OP_LOAD_TONE:
            begin
                freq_next = freq;
                mul_a     = {14'd0, freq};
                mul_b     = {2'd0, RECIP_QUO};
                prod_next = mul_p[38:0];
            end
            OP_TONE_B:
            begin
                quo_next  = prod_reg[32:23];
                mul_a     = {20'd0, prod_reg[32:23]};
                mul_b     = 19'(RATE_ODD);
                prod_next = mul_p[38:0];
            end
            OP_TONE_C:
            begin
                rem_next  = rem_wide[6:0];
                mul_a     = {23'd0, rem_wide[6:0]};
                mul_b     = STEP_WHOLE;
                prod_next = mul_p[38:0];
            end
            OP_TONE_D:
            begin
                acc_next  = {quo_reg[6:0], 25'd0} + prod_reg[31:0];
                mul_a     = {23'd0, rem_reg};
                mul_b     = {13'd0, STEP_FRAC};
                prod_next = mul_p[38:0];
            end
            OP_TONE_E:
            begin
                mul_a     = {17'd0, prod_reg[12:0]};
                mul_b     = {5'd0, RECIP_FRC};
                prod_next = mul_p[38:0];
            end
            OP_TONE_COMMIT:
            begin
                if ((freq_reg != 16'd0) && (tone_step_reg == 32'd0))
                begin
                    phase_next = 32'd0;
                end
                tone_step_next = step_new;
                if (step_new != 32'd0)
                begin
                    held_step_next = step_new;
                end
                target_next = (freq_reg != 16'd0) ? ENV_FULL : 9'd0;
            end
            OP_SILENCE:
            begin
                gain_next      = 9'd0;
                target_next    = 9'd0;
                tone_step_next = 32'd0;
            end
            default:
            begin
                mul_a = 30'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 32'd0;
            tone_step_reg <= 32'd0;
            held_step_reg <= 32'd0;
            gain_reg      <= 9'd0;
            target_reg    <= 9'd0;
            amp_reg       <= AMP_RESET;
            ramp_reg      <= RAMP_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            tone_step_reg <= tone_step_next;
            held_step_reg <= held_step_next;
            gain_reg      <= gain_next;
            target_reg    <= target_next;
            amp_reg       <= amp_next;
            ramp_reg      <= ramp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        freq_reg   <= freq_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        active_reg <= active_next;
        sample_reg <= sample_next;
    end

    assign sample = sample_reg;

endmodule

`default_nettype wire

// ===== design/dds_tone_generator_with_envelope.sv =====
// top level of the dds sine tone generator with linear gain envelope
// depends on dtg_pkg, dtg_ctrl and dtg_datapath
//
// usage:
//   item channel (item_valid/item_ready, mode, freq) carries one command per transaction:
//   sample tick, set tone frequency or force silence. only a sample tick gives a
//   transaction on the sample channel (sample_valid/sample_ready, sample).
//   cfg_write with cfg_index/cfg_data sets tone amplitude (index 0) or ramp step (index 1).
// timing:
//   a sample tick does the table lookup and envelope update at acceptance, then two
//   passes through the one shared multiplier, then the divide by full scale, after
//   which sample_valid rises. a set-tone turns the frequency into a phase step with
//   five passes through the same multiplier and then a commit step. force silence
//   is done at acceptance, and the controller stays in idle.
//   the next item is accepted as soon as the controller is back in idle.
// reset:
//   rst_n clears phase, steps and gain; amplitude returns to 9000, ramp step to 4.
// stall:
//   a finished sample sits in the output register; the next item is still accepted,
//   and a following tick holds in its last step until the output register is free.
`default_nettype none

module dds_tone_generator_with_envelope
    import dtg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic [1:0]         mode,
    input  wire logic [15:0]        freq,
    output logic                    sample_valid,
    input  wire logic               sample_ready,
    output logic signed [15:0]      sample,
    input  wire logic               cfg_write,
    input  wire logic               cfg_index,
    input  wire logic [14:0]        cfg_data
);

    cmd_t cmd;

    dtg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .cmd          (cmd)
    );

    dtg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .freq      (freq),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample)
    );

endmodule

`default_nettype wire

// ===== test/dds_tone_generator_with_envelope_tb.sv =====
// self-checking testbench for the dds sine tone generator with linear gain envelope
// keeps its own model of phase, steps and gain, and checks every sample against it
// depends on dtg_pkg and dds_tone_generator_with_envelope
`default_nettype none

module dds_tone_generator_with_envelope_tb;
    import dtg_pkg::*;

    localparam int unsigned TONE_RATE         = 16000;
    localparam int unsigned FULL_GAIN         = 256;
    localparam int unsigned FULL_SCALE        = 32767;
    localparam int unsigned ITEMS_PER_SETTING = 230;
    localparam int unsigned SETTLE_CYCLES     = 12;
    localparam int unsigned HOLD_CYCLES       = 400;
    localparam int unsigned CYCLE_LIMIT       = 1000000;
    localparam int unsigned NUM_SETTINGS      = 7;
    localparam logic [1:0]  MODE_UNUSED       = 2'd3;

    class tone_scoreboard;
        logic [14:0]        amplitude;
        logic [8:0]         ramp;
        logic [31:0]        phase;
        logic [31:0]        step_now;
        logic [31:0]        step_held;
        int unsigned        gain;
        int unsigned        target;
        int unsigned        sine_quarter [0:64];
        logic signed [15:0] expected_samples [$];
        int unsigned        errors;
        int unsigned        checked;

        function new();
            amplitude = AMP_RESET;
            ramp      = RAMP_RESET;
            phase     = '0;
            step_now  = '0;
            step_held = '0;
            gain      = 0;
            target    = 0;
            errors    = 0;
            checked   = 0;
            sine_quarter = '{
                    0,   804,  1608,  2410,  3212,  4011,  4808,  5602,
                 6393,  7179,  7962,  8739,  9512, 10278, 11039, 11793,
                12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
                18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
                23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
                27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
                30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
                32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757,
                32767
            };
        endfunction

        function void write_reg(logic index, logic [14:0] data);
            if (index == CFG_AMP)
                amplitude = data;
            else
                ramp = data[8:0];
        endfunction

        function void note_item(logic [1:0] item_mode, logic [15:0] item_freq);
            logic [63:0]     num;
            logic [31:0]     new_step;
            logic [31:0]     step_use;
            logic [7:0]      idx;
            logic [6:0]      q;
            int unsigned     m_idx;
            longint unsigned mag;
            logic [15:0]     result;
            case (item_mode)
                MODE_TONE:
                begin
                    num      = {16'd0, item_freq, 32'd0};
                    new_step = 32'(num / 64'(TONE_RATE));
                    if (item_freq != 0 && step_now == 0)
                        phase = '0;
                    step_now = new_step;
                    if (new_step != 0)
                        step_held = new_step;
                    target = (item_freq != 0) ? FULL_GAIN : 0;
                end
                MODE_SILENCE:
                begin
                    gain     = 0;
                    target   = 0;
                    step_now = '0;
                end
                MODE_TICK:
                begin
                    step_use = (step_now != 0) ? step_now : step_held;
                    if (gain < target)
                        gain = (gain + ramp > target) ? target : gain + ramp;
                    else if (gain > target)
                        gain = (gain > ramp + target) ? gain - ramp : target;
                    result = '0;
                    if (gain != 0 && step_use != 0)
                    begin
                        idx   = phase[31:24];
                        q     = idx[6:0];
                        m_idx = (q <= 7'd64) ? q : 128 - q;
                        mag   = sine_quarter[m_idx];
                        mag   = mag * amplitude;
                        mag   = mag * gain;
                        mag   = mag / (FULL_SCALE * FULL_GAIN);
                        result = mag[15:0];
                        if (idx[7])
                            result = -result;
                        phase = phase + step_use;
                    end
                    expected_samples.push_back(result);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_sample(logic signed [15:0] got);
            logic signed [15:0] want;
            if (expected_samples.size() == 0)
            begin
                errors++;
                $display("%0t: sample %0d arrived with no tick waiting", $time, got);
            end
            else
            begin
                want = expected_samples.pop_front();
                checked++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: sample mismatch, expected %0d, actual %0d", $time, want, got);
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic [1:0]         mode;
    logic [15:0]        freq;
    logic               sample_valid;
    logic               sample_ready;
    logic signed [15:0] sample;
    logic               cfg_write;
    logic               cfg_index;
    logic [14:0]        cfg_data;

    tone_scoreboard sb;
    bit             hold_req;
    bit             calm;
    int unsigned    cycle_count;
    int unsigned    useful_items;
    int unsigned    tick_count;
    int unsigned    tone_count;
    int unsigned    silence_count;
    int unsigned    unused_count;
    int unsigned    setting_count;

    dds_tone_generator_with_envelope i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .mode         (mode),
        .freq         (freq),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("dds_tone_generator_with_envelope_tb: FAIL");
            $finish;
        end
    end

    // sample receiver with random stalls and one long hold-off on request
    initial
    begin
        int unsigned run_left;
        bit          run_val;
        run_left     = 0;
        run_val      = 1'b0;
        sample_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                run_val  = 1'b0;
                run_left = HOLD_CYCLES;
            end
            else if (run_left == 0)
            begin
                if (calm)
                begin
                    run_val  = 1'b1;
                    run_left = 20;
                end
                else if (run_val)
                begin
                    run_val  = 1'b0;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                           : $urandom_range(1, 3);
                end
                else
                begin
                    run_val  = 1'b1;
                    run_left = $urandom_range(1, 25);
                end
            end
            run_left--;
            sample_ready = run_val;
            @(posedge clk);
            if (sample_valid && sample_ready)
                sb.check_sample(sample);
        end
    end

    task automatic idle_input(input int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            item_valid = 1'b0;
            mode       = 2'($urandom);
            freq       = 16'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_item(input logic [1:0] m_in, input logic [15:0] f_in);
        int unsigned r;
        @(negedge clk);
        item_valid = 1'b1;
        mode       = m_in;
        freq       = f_in;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(m_in, f_in);
        case (m_in)
            MODE_TICK:    tick_count++;
            MODE_TONE:    tone_count++;
            MODE_SILENCE: silence_count++;
            default:      unused_count++;
        endcase
        if (m_in != MODE_UNUSED)
            useful_items++;
        r = $urandom_range(0, 99);
        if (!calm && r >= 60)
            idle_input((r < 96) ? $urandom_range(1, 3) : $urandom_range(20, 50));
    endtask

    task automatic drain_samples();
        idle_input(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic idx, input logic [14:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.write_reg(idx, data);
    endtask

    // at most one command followed by a run of ticks
    task automatic play_burst();
        int unsigned r;
        int unsigned ticks;
        logic [15:0] f;
        calm = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            f = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(20, 8000));
            send_item(MODE_TONE, f);
        end
        else if (r < 52)
            send_item(MODE_TONE, 16'd0);
        else if (r < 60)
            send_item(MODE_TONE, 16'(TONE_RATE * $urandom_range(1, 4)));
        else if (r < 70)
            send_item(MODE_SILENCE, 16'($urandom));
        else if (r < 75)
            send_item(MODE_UNUSED, 16'($urandom));
        ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 30);
        repeat (ticks) send_item(MODE_TICK, 16'($urandom));
    endtask

    initial
    begin
        int unsigned amp_set  [NUM_SETTINGS];
        int unsigned ramp_set [NUM_SETTINGS];
        int unsigned start;
        bit          hold_done;
        bit          pause_done;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        mode       = MODE_TICK;
        freq       = '0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_AMP;
        cfg_data   = '0;
        hold_req   = 1'b0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();

        amp_set  = '{9000, 32767, 0, 32767, 1, 0, 32767};
        ramp_set = '{4, 256, 1, 0, 256, 0, 1};
        amp_set[5]  = $urandom_range(0, 32767);
        ramp_set[5] = $urandom_range(1, 256);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: silent tick, ignored mode, stop, wrapping steps, extremes, silence
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_UNUSED, 16'hFFFF);
        send_item(MODE_TONE, 16'd0);
        send_item(MODE_TICK, 16'hFFFF);
        send_item(MODE_TONE, 16'd1000);
        repeat (5) send_item(MODE_TICK, 16'd0);
        send_item(MODE_TONE, 16'd1);
        repeat (2) send_item(MODE_TICK, 16'd0);
        send_item(MODE_TONE, 16'(TONE_RATE));
        repeat (2) send_item(MODE_TICK, 16'd0);
        send_item(MODE_TONE, 16'hFFFF);
        repeat (2) send_item(MODE_TICK, 16'd0);
        send_item(MODE_SILENCE, 16'hFFFF);
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_TONE, 16'(2 * TONE_RATE));
        send_item(MODE_TICK, 16'd0);
        send_item(MODE_TONE, 16'd0);
        send_item(MODE_TICK, 16'd0);

        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            if (ph > 0)
            begin
                drain_samples();
                set_register(CFG_AMP, 15'(amp_set[ph]));
                set_register(CFG_RAMP, {6'($urandom), 9'(ramp_set[ph])});
            end
            setting_count++;
            start = useful_items;
            while (useful_items - start < ITEMS_PER_SETTING)
            begin
                play_burst();
                if (!hold_done && ph == 1 && useful_items - start > 100)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (!pause_done && ph == 4 && useful_items - start > 100)
                begin
                    idle_input(1);
                    while (sb.pending() != 0)
                        @(posedge clk);
                    pause_done = 1'b1;
                end
            end
        end

        drain_samples();
        repeat (20) @(posedge clk);

        $display("covered %0d transactions: %0d ticks, %0d tone sets, %0d silences, %0d ignored",
                 useful_items + unused_count, tick_count, tone_count, silence_count,
                 unused_count);
        $display("%0d samples checked over %0d register settings, %0d mismatches",
                 sb.checked, setting_count, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("dds_tone_generator_with_envelope_tb: PASS");
        else
            $display("dds_tone_generator_with_envelope_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
